// ===== hdl/sbl_pkg.sv =====
// Shared constants, types and arithmetic helpers for the 5x5 separable blur.
package sbl_pkg;

  localparam int MaxWidth  = 2048;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int PosW      = ColW + 1;
  localparam int CfgW      = 12;
  localparam int RowW      = CfgW + 1;
  localparam int PixW      = 8;
  localparam int SumW      = PixW + 4;
  localparam int RowBanks  = 4;
  localparam int BankW     = $clog2(RowBanks);
  localparam int MinDim    = 5;
  localparam int ApbAddrW  = 3;
  localparam int DataW     = 32;

  // Division by ten as a multiply by 6554 / 2^16; exact for sums up to 10 * 255.
  localparam int MulW      = 13;
  localparam int DivShift  = 16;
  localparam logic [MulW-1:0] Div10Mul = MulW'(6554);

  localparam logic [CfgW-1:0] WidthReset  = CfgW'(640);
  localparam logic [CfgW-1:0] HeightReset = CfgW'(480);

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Per-request control that travels down the pipeline.
  typedef struct packed {
    logic             hvalid;
    logic             tap_h;
    logic [BankW-1:0] hbank;
    logic [ColW-1:0]  addr;
    logic             active;
    logic             vert;
    logic [BankW-1:0] obank;
    logic             fend;
  } stage_t;

  // Stage enables and control seen by every channel lane.
  typedef struct packed {
    logic             shift;
    logic             ld2;
    logic             ld3;
    logic             ld4;
    logic             ld5;
    logic             out_ld;
    logic             tap_h;
    logic             we;
    logic [BankW-1:0] wbank;
    logic [ColW-1:0]  addr;
    logic [BankW-1:0] obank;
    logic             vert5;
  } lane_ctl_t;

  function automatic logic [SumW-1:0] tap_sum(input logic [PixW-1:0] a,
                                              input logic [PixW-1:0] b,
                                              input logic [PixW-1:0] c,
                                              input logic [PixW-1:0] d,
                                              input logic [PixW-1:0] e);
    return SumW'(a) + (SumW'(b) << 1) + (SumW'(c) << 2) + (SumW'(d) << 1) + SumW'(e);
  endfunction

  function automatic logic [PixW-1:0] div10(input logic [SumW-1:0] x);
    logic [SumW+MulW-1:0] prod;
    prod = (SumW+MulW)'(x) * (SumW+MulW)'(Div10Mul);
    return prod[DivShift +: PixW];
  endfunction

  function automatic logic [PosW-1:0] clamp_width(input logic [CfgW-1:0] v);
    if (int'(v) < MinDim) begin
      return PosW'(MinDim);
    end else if (int'(v) > MaxWidth) begin
      return PosW'(MaxWidth);
    end
    return PosW'(v);
  endfunction

  function automatic logic [CfgW-1:0] clamp_height(input logic [CfgW-1:0] v);
    if (int'(v) < MinDim) begin
      return CfgW'(MinDim);
    end
    return v;
  endfunction

endpackage

// ===== hdl/sbl_ctrl.sv =====
// Position counters, configuration registers and pipeline flow control for the blur.
module sbl_ctrl import sbl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready,
  input  logic                pix_valid,
  output logic                pix_stall,
  input  logic                res_stall,
  output logic                res_valid,
  output logic                frame_end,
  output lane_ctl_t           lane_ctl
);

  localparam int NumStages = 5;

  logic [CfgW-1:0] width_cfg;
  logic [CfgW-1:0] height_cfg;
  logic [PosW-1:0] width_eff;
  logic [CfgW-1:0] height_eff;

  logic [ColW-1:0] in_col;
  logic [RowW-1:0] in_row;
  logic [ColW-1:0] out_col;
  logic [CfgW-1:0] out_row;

  stage_t                cur;
  stage_t                stg [1:NumStages];
  logic [NumStages:1]    vld;
  logic [NumStages:1]    go;

  logic     cfg_wr;
  reg_idx_t reg_idx;
  logic     accept;
  logic     out_en;
  logic     out_ld;
  logic     col_ge2;
  logic [PosW-1:0] hc_wide;
  logic [RowW-1:0] hr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[ApbAddrW-1]);

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = {(DataW-CfgW)'(0), width_cfg};
      REG_HEIGHT: prdata = {(DataW-CfgW)'(0), height_cfg};
      default:    prdata = '0;
    endcase
  end

  // Horizontal result belongs to the pixel two requests back.
  always_comb begin
    col_ge2 = in_col >= ColW'(2);
    hr      = col_ge2 ? in_row : in_row - RowW'(1);
    hc_wide = col_ge2 ? PosW'(in_col) - PosW'(2) : width_eff - PosW'(2) + PosW'(in_col);

    cur.hvalid = (col_ge2 || in_row != '0) && (hr < RowW'(height_eff));
    cur.hbank  = hr[BankW-1:0];
    cur.addr   = hc_wide[ColW-1:0];
    cur.tap_h  = (hc_wide >= PosW'(2)) &&
                 ((PosW+1)'(hc_wide) + (PosW+1)'(3) <= (PosW+1)'(width_eff));
    cur.active = (in_row > RowW'(2)) || (in_row == RowW'(2) && col_ge2);
    cur.vert   = (out_row >= CfgW'(2)) &&
                 ((CfgW+1)'(out_row) + (CfgW+1)'(2) < (CfgW+1)'(height_eff)) && cur.hvalid;
    cur.obank  = out_row[BankW-1:0];
    cur.fend   = ((CfgW+1)'(out_row) + (CfgW+1)'(1) == (CfgW+1)'(height_eff)) &&
                 (PosW'(out_col) + PosW'(1) == width_eff);
  end

  // A stage may load when it is empty or its request moves on; requests that
  // produce no result leave the last stage without touching the output register.
  always_comb begin
    out_en        = !res_valid || !res_stall;
    go[NumStages] = !vld[NumStages] || !stg[NumStages].active || out_en;
    for (int k = NumStages - 1; k >= 1; k--) begin
      go[k] = !vld[k] || go[k+1];
    end
  end

  assign accept    = pix_valid && go[1];
  assign pix_stall = !go[1];
  assign out_ld    = out_en && vld[NumStages] && stg[NumStages].active;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= WidthReset;
      height_cfg <= HeightReset;
      width_eff  <= clamp_width(WidthReset);
      height_eff <= clamp_height(HeightReset);
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIDTH: begin
          width_cfg <= pwdata[CfgW-1:0];
          width_eff <= clamp_width(pwdata[CfgW-1:0]);
        end
        REG_HEIGHT: begin
          height_cfg <= pwdata[CfgW-1:0];
          height_eff <= clamp_height(pwdata[CfgW-1:0]);
        end
        default: begin
        end
      endcase
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (accept) begin
      if (cur.active && cur.fend) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (cur.active) begin
          if (PosW'(out_col) + PosW'(1) >= width_eff) begin
            out_col <= '0;
            out_row <= out_row + CfgW'(1);
          end else begin
            out_col <= out_col + ColW'(1);
          end
        end
        if (PosW'(in_col) + PosW'(1) >= width_eff) begin
          in_col <= '0;
          in_row <= in_row + RowW'(1);
        end else begin
          in_col <= in_col + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (go[1]) begin
        vld[1] <= accept;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (go[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (out_en) begin
        res_valid <= vld[NumStages] && stg[NumStages].active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[1]) begin
      stg[1] <= cur;
    end
    for (int k = 2; k <= NumStages; k++) begin
      if (go[k]) begin
        stg[k] <= stg[k-1];
      end
    end
    if (out_ld) begin
      frame_end <= stg[NumStages].fend;
    end
  end

  always_comb begin
    lane_ctl.shift  = accept;
    lane_ctl.ld2    = go[2];
    lane_ctl.ld3    = go[3];
    lane_ctl.ld4    = go[4];
    lane_ctl.ld5    = go[5];
    lane_ctl.out_ld = out_ld;
    lane_ctl.tap_h  = stg[2].tap_h;
    lane_ctl.we     = go[4] && vld[3] && stg[3].hvalid;
    lane_ctl.wbank  = stg[3].hbank;
    lane_ctl.addr   = stg[3].addr;
    lane_ctl.obank  = stg[4].obank;
    lane_ctl.vert5  = stg[5].vert;
  end

endmodule

// ===== hdl/sbl_lane.sv =====
// One color channel: source window, horizontal taps, row store and vertical taps.
module sbl_lane import sbl_pkg::*; (
  input  logic            clk,
  input  lane_ctl_t       ctl,
  input  logic [PixW-1:0] pix,
  output logic [PixW-1:0] res
);

  logic [PixW-1:0] win [5];
  logic [SumW-1:0] hsum;
  logic [PixW-1:0] hctr;
  logic [PixW-1:0] hval;
  logic [PixW-1:0] hval4;
  logic [PixW-1:0] rd [RowBanks];
  logic [SumW-1:0] vsum;
  logic [PixW-1:0] vctr;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int t = 0; t < 4; t++) begin
        win[t] <= win[t+1];
      end
      win[4] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      hsum <= tap_sum(win[0], win[1], win[2], win[3], win[4]);
      hctr <= win[2];
    end
    if (ctl.ld3) begin
      hval <= ctl.tap_h ? div10(hsum) : hctr;
    end
    if (ctl.ld4) begin
      hval4 <= hval;
    end
  end

  // Four row banks; each is read at the current column while the oldest row's
  // bank takes the new horizontal result (read returns the old contents).
  for (genvar b = 0; b < RowBanks; b++) begin : g_bank
    logic [PixW-1:0] mem [MaxWidth];

    always_ff @(posedge clk) begin
      if (ctl.ld4) begin
        rd[b] <= mem[ctl.addr];
        if (ctl.we && ctl.wbank == BankW'(b)) begin
          mem[ctl.addr] <= hval;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld5) begin
      vsum <= tap_sum(rd[BankW'(ctl.obank + BankW'(2))],
                      rd[BankW'(ctl.obank + BankW'(3))],
                      rd[ctl.obank],
                      rd[BankW'(ctl.obank + BankW'(1))],
                      hval4);
      vctr <= rd[ctl.obank];
    end
  end

  assign res = ctl.vert5 ? div10(vsum) : vctr;

endmodule

// ===== hdl/separable_blur_5x5_stream_core.sv =====
// Top level of the streaming 5x5 separable blur for BGR pixels.
//
// The block takes one BGR pixel request per clock, unless stalled, in raster order
// and returns the blurred frame with a lag of 2*image_width+2 requests: the first
// 2*image_width+2 requests of a frame give no result, and after the last pixel the
// user sends 2*image_width+2 flush requests to drain the rest. The pipeline
// sustains one request per clock unless stalled; the row store, one read and one
// write per bank per cycle, sets that figure. Three identical lanes, one per color
// channel, each apply the 1,2,4,2,1 taps horizontally and then vertically, dividing
// by ten with truncation; the two outer columns and the two outer rows on each side
// keep the unfiltered value of that pass. Each lane keeps the last four rows of
// horizontal results in four banks of 2048 entries that need no clearing after
// reset. The output stage merges the three lane results with frame_end, which
// marks the last pixel of the frame. image_width (clamped to 5..2048) at byte
// address 0 and image_height (at least 5) at byte address 4 are written by the user
// over the APB port only while the block is idle, which the block does not enforce;
// every write restarts the frame. Input stall rises only while a finished result
// waits in the output register and every pipeline stage is occupied.
module separable_blur_5x5_stream_core import sbl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [DataW-1:0]    pwdata,
  output logic [DataW-1:0]    prdata,
  output logic                pready,
  input  logic                pix_valid,
  output logic                pix_stall,
  input  logic [PixW-1:0]     in_blue,
  input  logic [PixW-1:0]     in_green,
  input  logic [PixW-1:0]     in_red,
  input  logic                flush,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [PixW-1:0]     out_blue,
  output logic [PixW-1:0]     out_green,
  output logic [PixW-1:0]     out_red,
  output logic                frame_end
);

  lane_ctl_t       lane_ctl;
  logic [PixW-1:0] pix_blue;
  logic [PixW-1:0] pix_green;
  logic [PixW-1:0] pix_red;
  logic [PixW-1:0] res_blue;
  logic [PixW-1:0] res_green;
  logic [PixW-1:0] res_red;

  sbl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .frame_end (frame_end),
    .lane_ctl  (lane_ctl)
  );

  // A flush request enters the window as a black pixel.
  assign pix_blue  = flush ? '0 : in_blue;
  assign pix_green = flush ? '0 : in_green;
  assign pix_red   = flush ? '0 : in_red;

  sbl_lane u_lane_blue (
    .clk (clk),
    .ctl (lane_ctl),
    .pix (pix_blue),
    .res (res_blue)
  );

  sbl_lane u_lane_green (
    .clk (clk),
    .ctl (lane_ctl),
    .pix (pix_green),
    .res (res_green)
  );

  sbl_lane u_lane_red (
    .clk (clk),
    .ctl (lane_ctl),
    .pix (pix_red),
    .res (res_red)
  );

  // Output register: the three channel results are merged into one result here,
  // and they hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (lane_ctl.out_ld) begin
      out_blue  <= res_blue;
      out_green <= res_green;
      out_red   <= res_red;
    end
  end

endmodule

// ===== hdl/sbl_checker.sv =====
// Port-level checks for the separable blur core and the bind that attaches them.
module sbl_checker import sbl_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [ApbAddrW-1:0] paddr,
  input logic [DataW-1:0]    pwdata,
  input logic [DataW-1:0]    prdata,
  input logic                pready,
  input logic                pix_valid,
  input logic                pix_stall,
  input logic [PixW-1:0]     in_blue,
  input logic [PixW-1:0]     in_green,
  input logic [PixW-1:0]     in_red,
  input logic                flush,
  input logic                res_valid,
  input logic                res_stall,
  input logic [PixW-1:0]     out_blue,
  input logic [PixW-1:0]     out_green,
  input logic [PixW-1:0]     out_red,
  input logic                frame_end
);

  // The input side only backs up when a result is waiting and being stalled.
  a_stall_needs_blocked_output: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (res_valid && res_stall))
    else $error("input stalled while output was free");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(out_blue) && $stable(out_green) &&
                                  $stable(out_red) && $stable(frame_end)))
    else $error("stalled result changed or vanished");

  // A register reads back what was last written to it.
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite) ##1 (psel && !pwrite && paddr == $past(paddr)) |->
      (prdata[CfgW-1:0] == $past(pwdata[CfgW-1:0]) && prdata[DataW-1:CfgW] == '0))
    else $error("configuration readback mismatch");

  a_no_result_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind separable_blur_5x5_stream_core sbl_checker u_sbl_checker (.*);
